// ----- rtl/core/elcwa_pkg.sv -----
// shared types and codes for the endpoint learning cache
`default_nettype none

package elcwa_pkg;

    // request types
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_LEARN  = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // key kinds
    localparam logic [1:0] KIND_IPV4  = 2'd0;
    localparam logic [1:0] KIND_IPV6  = 2'd1;
    localparam logic [1:0] KIND_MAC   = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_LEARNED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [15:0] LIFETIME_RESET = 16'd60;

    // one table entry as it travels round the ring
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [7:0]  endpoint;
        logic [15:0] ttl;
    } t_entry;

    // controls from the sequencer to the head cell
    typedef struct packed {
        logic        search;
        logic        tick;
        logic        insert_here;
        logic [1:0]  kind;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [7:0]  endpoint;
        logic [15:0] lifetime;
        logic [7:0]  elapsed;
    } t_head_ctl;

    // what the head cell saw in the entry passing through it
    typedef struct packed {
        logic       matched;
        logic       is_free;
        logic       aged_out;
        logic [7:0] endpoint;
    } t_head_stat;

endpackage

`default_nettype wire

// ----- rtl/core/endpoint_learning_cache_with_aging_unit.sv -----
// top level of the endpoint learning cache: entry ring, head cell and request sequencer
//
//  channel   direction  handshake                 contents
//  s (req)   in         i_s_tvalid / o_s_tready   tdata keys, endpoint, elapsed; tuser type, kind
//  m (res)   out        o_m_tvalid / i_m_tready   tdata endpoint, removed; tuser hit, status
//  cfg       in         i_cfg_valid / o_cfg_ready entry lifetime in seconds
//
// the table is a ring of ENTRIES cells that rotates one place a cycle past a single head cell
// during a scan or an insert; lookup, learn hit, learn with table full and tick scan once
// learn that inserts: a second rotation writes the free slot
// unknown request type or key kind: the ring does not move
// synchronous active-low reset empties the table at once (valid flags only)
// one request at a time; a result waiting on the m side holds the finish step
`default_nettype none

module endpoint_learning_cache_with_aging_unit #(
    parameter int ENTRIES = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // request words
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [143:0] i_s_tdata,   // key_high, key_low, endpoint_id, elapsed
    input  wire logic [3:0]   i_s_tuser,   // req_type, key_kind
    // result words
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [15:0]       o_m_tdata,   // endpoint_out, removed_count, 1 bit zero pad
    output logic [2:0]        o_m_tuser,   // hit, status
    // lifetime register
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [15:0]  i_cfg_data
);

    localparam int PW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;

    // lifetime register
    logic [15:0] r_lifetime;

    // captured request
    logic [1:0]  r_req;
    logic [1:0]  r_kind;
    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic [7:0]  r_ep_in;
    logic [7:0]  r_elapsed;

    // scan bookkeeping
    logic [PW-1:0] r_pos;
    logic          r_hit;
    logic [7:0]    r_ep_found;
    logic          r_free_found;
    logic [PW-1:0] r_free_idx;
    logic [CW-1:0] r_removed;
    logic [1:0]    r_status;

    // output register
    logic          r_m_valid;
    logic          r_m_hit;
    logic [1:0]    r_m_status;
    logic [7:0]    r_m_ep;
    logic [6:0]    r_m_removed;

    // ring
    elcwa_pkg::t_entry     w_cell_q [ENTRIES];
    elcwa_pkg::t_entry     w_head_out;
    elcwa_pkg::t_head_ctl  w_ctl;
    elcwa_pkg::t_head_stat w_stat;
    logic                  w_shift;

    logic          w_s_acc;
    logic          w_last;
    logic          w_bad_req;
    logic          w_free_fin;
    logic [CW-1:0] w_rem_fin;
    logic [31:0]   w_rem32;

    assign w_s_acc   = i_s_tvalid && o_s_tready;
    assign w_shift   = (r_state == S_SCAN) || (r_state == S_INSERT);
    assign w_last    = (r_pos == LAST_POS);
    // unknown type, or a lookup / learn with an unknown key kind
    assign w_bad_req = (i_s_tuser[1:0] != elcwa_pkg::REQ_LOOKUP) &&
                       (i_s_tuser[1:0] != elcwa_pkg::REQ_LEARN) &&
                       (i_s_tuser[1:0] != elcwa_pkg::REQ_TICK) ||
                       (i_s_tuser[1:0] != elcwa_pkg::REQ_TICK) &&
                       (i_s_tuser[3:2] == elcwa_pkg::KIND_BAD);

    // head cell controls
    always_comb begin
        w_ctl.search      = (r_state == S_SCAN) && (r_req != elcwa_pkg::REQ_TICK);
        w_ctl.tick        = (r_state == S_SCAN) && (r_req == elcwa_pkg::REQ_TICK);
        w_ctl.insert_here = (r_state == S_INSERT) && (r_pos == r_free_idx);
        w_ctl.kind        = r_kind;
        w_ctl.key_high    = r_key_high;
        w_ctl.key_low     = r_key_low;
        w_ctl.endpoint    = r_ep_in;
        w_ctl.lifetime    = r_lifetime;
        w_ctl.elapsed     = r_elapsed;
    end

    elcwa_head u_head (
        .i_entry (w_cell_q[0]),
        .i_ctl   (w_ctl),
        .o_entry (w_head_out),
        .o_stat  (w_stat)
    );

    // cell k takes cell k+1, the tail takes what the head cell hands back
    for (genvar k = 0; k < ENTRIES; k++) begin : g_ring
        if (k == ENTRIES - 1) begin : g_tail
            elcwa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_head_out),
                .o_q     (w_cell_q[k])
            );
        end else begin : g_body
            elcwa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_cell_q[k+1]),
                .o_q     (w_cell_q[k])
            );
        end
    end

    // final-cycle values of the scan, including the entry at the head now
    assign w_free_fin = r_free_found || w_stat.is_free;
    assign w_rem_fin  = r_removed + CW'(w_stat.aged_out);
    assign w_rem32    = 32'(r_removed);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_state = w_bad_req ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    if ((r_req == elcwa_pkg::REQ_LEARN) && !(r_hit || w_stat.matched) &&
                        w_free_fin) begin
                        n_state = S_INSERT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_INSERT: begin
                if (w_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lifetime <= elcwa_pkg::LIFETIME_RESET;
            r_m_valid  <= 1'b0;
            r_pos      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lifetime <= i_cfg_data;
            end
            if (w_shift) begin
                r_pos <= w_last ? '0 : r_pos + 1'b1;
            end
            if ((r_state == S_FINISH) && (!r_m_valid || i_m_tready)) begin
                r_m_valid   <= 1'b1;
                r_m_hit     <= r_hit;
                r_m_status  <= r_status;
                r_m_ep      <= r_ep_found;
                // removed count saturates at the field's top
                r_m_removed <= (w_rem32 > 32'd127) ? 7'd127 : w_rem32[6:0];
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    r_req        <= i_s_tuser[1:0];
                    r_kind       <= i_s_tuser[3:2];
                    r_key_high   <= i_s_tdata[63:0];
                    r_key_low    <= i_s_tdata[127:64];
                    r_ep_in      <= i_s_tdata[135:128];
                    r_elapsed    <= i_s_tdata[143:136];
                    r_hit        <= 1'b0;
                    r_ep_found   <= 8'd0;
                    r_free_found <= 1'b0;
                    r_free_idx   <= '0;
                    r_removed    <= '0;
                    r_status     <= elcwa_pkg::ST_MISS;
                end
            end
            S_SCAN: begin
                if (w_stat.matched) begin
                    r_hit      <= 1'b1;
                    r_ep_found <= w_stat.endpoint;
                end
                if (w_stat.is_free && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_pos;
                end
                r_removed <= w_rem_fin;
                if (w_last) begin
                    if (r_req == elcwa_pkg::REQ_TICK) begin
                        r_status <= elcwa_pkg::ST_HIT;
                    end else if (r_hit || w_stat.matched) begin
                        r_status <= elcwa_pkg::ST_HIT;
                    end else if (r_req == elcwa_pkg::REQ_LEARN) begin
                        r_status <= w_free_fin ? elcwa_pkg::ST_LEARNED : elcwa_pkg::ST_FULL;
                    end else begin
                        r_status <= elcwa_pkg::ST_MISS;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {1'b0, r_m_removed, r_m_ep};
    assign o_m_tuser   = {r_m_status, r_m_hit};

endmodule

`default_nettype wire

// ----- rtl/core/elcwa_cell.sv -----
// one storage cell of the entry ring
`default_nettype none

module elcwa_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire elcwa_pkg::t_entry i_d,
    output elcwa_pkg::t_entry      o_q
);

    logic              r_valid;
    elcwa_pkg::t_entry r_body;

    // only the valid flag is reset, the rest is written before it counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_body <= i_d;
        end
    end

    always_comb begin
        o_q       = r_body;
        o_q.valid = r_valid;
    end

endmodule

`default_nettype wire

// ----- rtl/core/elcwa_head.sv -----
// head cell: match, refresh, age and insert on the entry passing the ring head
`default_nettype none

module elcwa_head (
    input  wire elcwa_pkg::t_entry    i_entry,
    input  wire elcwa_pkg::t_head_ctl i_ctl,
    output elcwa_pkg::t_entry         o_entry,
    output elcwa_pkg::t_head_stat     o_stat
);

    logic w_match;
    logic w_aged;

    assign w_match = i_ctl.search && i_entry.valid && (i_entry.kind == i_ctl.kind) &&
                     (i_entry.key_high == i_ctl.key_high) &&
                     (i_entry.key_low == i_ctl.key_low);
    assign w_aged  = i_ctl.tick && i_entry.valid && ({8'd0, i_ctl.elapsed} >= i_entry.ttl);

    always_comb begin
        o_entry = i_entry;
        if (i_ctl.tick && i_entry.valid) begin
            if (w_aged) begin
                o_entry.valid = 1'b0;
            end else begin
                o_entry.ttl = i_entry.ttl - {8'd0, i_ctl.elapsed};
            end
        end
        if (w_match) begin
            o_entry.ttl = i_ctl.lifetime;
        end
        if (i_ctl.insert_here) begin
            o_entry.valid    = 1'b1;
            o_entry.kind     = i_ctl.kind;
            o_entry.key_high = i_ctl.key_high;
            o_entry.key_low  = i_ctl.key_low;
            o_entry.endpoint = i_ctl.endpoint;
            o_entry.ttl      = i_ctl.lifetime;
        end
    end

    assign o_stat.matched  = w_match;
    assign o_stat.is_free  = !i_entry.valid;
    assign o_stat.aged_out = w_aged;
    assign o_stat.endpoint = i_entry.endpoint;

endmodule

`default_nettype wire

// ----- rtl/core/elcwa_checker.sv -----
// port-level checks for the endpoint learning cache, bound to the top level
`default_nettype none

module elcwa_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [15:0]  o_m_tdata,
    input wire logic [2:0]   o_m_tuser
);

    // a request is never taken in the cycle after one was taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted back to back");

    // a stalled result stays put
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // a hit always reports the hit status
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tuser[2:1] == elcwa_pkg::ST_HIT))
        else $error("hit without hit status");

    // a miss carries no endpoint
    a_miss_endpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[7:0] == 8'd0))
        else $error("endpoint on a miss");

    // removals come only from a tick, which reports the hit status with the hit flag clear
    a_removed_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[14:8] != 7'd0)) |->
            (!o_m_tuser[0] && (o_m_tuser[2:1] == elcwa_pkg::ST_HIT)))
        else $error("removed count on a non-tick result");

endmodule

bind endpoint_learning_cache_with_aging_unit elcwa_checker u_elcwa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ----- bench/tb_endpoint_learning_cache_with_aging_unit.sv -----
// self-checking bench for the endpoint learning cache: directed and random requests, scored
module tb_endpoint_learning_cache_with_aging_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CACHE_SLOTS = 64;
    localparam int POOL_KEYS   = 80;
    // request type with no meaning, answered as a miss
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  key_kind;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [7:0]  endpoint_id;
        logic [7:0]  elapsed;
    } t_cache_req;

    typedef struct packed {
        logic       hit;
        logic [7:0] endpoint;
        logic [1:0] status;
        logic [6:0] removed;
    } t_cache_answer;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // request side
    logic         s_valid = 1'b0;
    logic [143:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         o_s_tready;
    // result side
    logic         o_m_tvalid;
    logic         m_ready = 1'b0;
    logic [15:0]  o_m_tdata;
    logic [2:0]   o_m_tuser;
    // lifetime register
    logic         cfg_valid = 1'b0;
    logic [15:0]  cfg_data = '0;
    logic         o_cfg_ready;

    endpoint_learning_cache_with_aging_unit #(
        .ENTRIES(CACHE_SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // key_high, key_low, endpoint_id, elapsed
        .i_s_tuser  (s_tuser),     // req_type, key_kind
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),   // endpoint_out, removed_count, zero pad
        .o_m_tuser  (o_m_tuser),   // hit, status
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // shadow table, kept in step with every accepted request word
    // ------------------------------------------------------------------
    logic        tbl_valid [CACHE_SLOTS];
    logic [1:0]  tbl_kind  [CACHE_SLOTS];
    logic [63:0] tbl_high  [CACHE_SLOTS];
    logic [63:0] tbl_low   [CACHE_SLOTS];
    logic [7:0]  tbl_ep    [CACHE_SLOTS];
    logic [15:0] tbl_ttl   [CACHE_SLOTS];
    logic [15:0] shadow_lifetime = elcwa_pkg::LIFETIME_RESET;

    initial begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    end

    // works out the answer to one request and updates the shadow table
    function automatic t_cache_answer predict_cache_answer(t_cache_req r);
        t_cache_answer a;
        int slot;
        int unsigned gone;
        a = '0;
        a.status = elcwa_pkg::ST_MISS;
        slot = -1;
        gone = 0;
        if (r.req_type == elcwa_pkg::REQ_TICK) begin
            // a tick answers with the hit code and ages every live entry
            a.status = elcwa_pkg::ST_HIT;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                if (tbl_valid[i]) begin
                    if ({8'd0, r.elapsed} >= tbl_ttl[i]) begin
                        tbl_valid[i] = 1'b0;
                        gone++;
                    end else begin
                        tbl_ttl[i] = tbl_ttl[i] - {8'd0, r.elapsed};
                    end
                end
            end
            a.removed = (gone > 127) ? 7'd127 : gone[6:0];
        end else if ((r.req_type == elcwa_pkg::REQ_LOOKUP ||
                      r.req_type == elcwa_pkg::REQ_LEARN) &&
                     r.key_kind != elcwa_pkg::KIND_BAD) begin
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                if (slot < 0 && tbl_valid[i] && tbl_kind[i] == r.key_kind &&
                    tbl_high[i] == r.key_high && tbl_low[i] == r.key_low)
                    slot = i;
            end
            if (slot >= 0) begin
                // hit: refresh lifetime, stored endpoint stays as it was
                tbl_ttl[slot] = shadow_lifetime;
                a.hit = 1'b1;
                a.endpoint = tbl_ep[slot];
                a.status = elcwa_pkg::ST_HIT;
            end else if (r.req_type == elcwa_pkg::REQ_LEARN) begin
                for (int i = 0; i < CACHE_SLOTS; i++) begin
                    if (slot < 0 && !tbl_valid[i])
                        slot = i;
                end
                if (slot < 0) begin
                    a.status = elcwa_pkg::ST_FULL;
                end else begin
                    tbl_valid[slot] = 1'b1;
                    tbl_kind[slot]  = r.key_kind;
                    tbl_high[slot]  = r.key_high;
                    tbl_low[slot]   = r.key_low;
                    tbl_ep[slot]    = r.endpoint_id;
                    tbl_ttl[slot]   = shadow_lifetime;
                    a.status = elcwa_pkg::ST_LEARNED;
                end
            end
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // request driver and result monitor
    // ------------------------------------------------------------------
    t_cache_req    request_backlog[$];
    t_cache_answer awaited_answers[$];
    t_cache_req    cur_req = '0;
    logic          req_taken = 1'b0;
    logic          res_taken = 1'b0;
    int unsigned   req_pause = 0;
    int unsigned   res_pause = 0;
    bit            sender_gappy = 1'b1;
    bit            receiver_gappy = 1'b1;
    bit            failed = 1'b0;

    function automatic int unsigned draw_pause(bit gappy);
        return gappy ? $urandom_range(0, 16) : 0;
    endfunction

    // sample both handshakes at the rising edge, predict and score there
    always @(posedge i_clk) begin
        t_cache_answer exp_a;
        t_cache_answer got_a;
        req_taken <= i_rst_n && s_valid && o_s_tready;
        res_taken <= i_rst_n && o_m_tvalid && m_ready;
        if (i_rst_n) begin
            if (s_valid && o_s_tready)
                awaited_answers.push_back(predict_cache_answer(cur_req));
            if (o_m_tvalid && m_ready) begin
                got_a.endpoint = o_m_tdata[7:0];
                got_a.removed  = o_m_tdata[14:8];
                got_a.hit      = o_m_tuser[0];
                got_a.status   = o_m_tuser[2:1];
                if (awaited_answers.size() == 0) begin
                    $error("result word with no request waiting");
                    failed = 1'b1;
                end else begin
                    exp_a = awaited_answers.pop_front();
                    if (got_a.hit !== exp_a.hit) begin
                        $error("hit: expected %0d, got %0d", exp_a.hit, got_a.hit);
                        failed = 1'b1;
                    end
                    if (got_a.endpoint !== exp_a.endpoint) begin
                        $error("endpoint_out: expected %0d, got %0d",
                               exp_a.endpoint, got_a.endpoint);
                        failed = 1'b1;
                    end
                    if (got_a.status !== exp_a.status) begin
                        $error("status: expected %0d, got %0d", exp_a.status, got_a.status);
                        failed = 1'b1;
                    end
                    if (got_a.removed !== exp_a.removed) begin
                        $error("removed_count: expected %0d, got %0d",
                               exp_a.removed, got_a.removed);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // request side: pause after each word, then present the next one
    always @(negedge i_clk) begin
        t_cache_req nxt;
        if (i_rst_n && (!s_valid || req_taken)) begin
            if (req_pause > 0) begin
                s_valid <= 1'b0;
                req_pause <= req_pause - 1;
            end else if (request_backlog.size() > 0) begin
                nxt = request_backlog.pop_front();
                cur_req <= nxt;
                s_tdata <= {nxt.elapsed, nxt.endpoint_id, nxt.key_low, nxt.key_high};
                s_tuser <= {nxt.key_kind, nxt.req_type};
                s_valid <= 1'b1;
                req_pause <= draw_pause(sender_gappy);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: stall for a drawn number of cycles after each word
    always @(negedge i_clk) begin
        int unsigned hold;
        if (i_rst_n) begin
            hold = res_taken ? draw_pause(receiver_gappy) : res_pause;
            if (hold > 0) begin
                m_ready <= 1'b0;
                res_pause <= hold - 1;
            end else begin
                m_ready <= 1'b1;
                res_pause <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    logic [1:0]  pool_kind [POOL_KEYS];
    logic [63:0] pool_high [POOL_KEYS];
    logic [63:0] pool_low  [POOL_KEYS];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_cache_req mk_req(logic [1:0] rt, logic [1:0] kd, logic [63:0] hi,
                                          logic [63:0] lo, logic [7:0] ep, logic [7:0] el);
        t_cache_req r;
        r.req_type = rt;
        r.key_kind = kd;
        r.key_high = hi;
        r.key_low = lo;
        r.endpoint_id = ep;
        r.elapsed = el;
        return r;
    endfunction

    // a well-formed key: ipv4 and mac zero extended, ipv6 across both halves
    function automatic t_cache_req shaped_key(logic [1:0] rt, logic [1:0] kd);
        t_cache_req r;
        r = mk_req(rt, kd, 64'd0, rand64(), 8'($urandom), 8'($urandom));
        case (kd)
            elcwa_pkg::KIND_IPV4: begin
                r.key_low[63:32] = '0;
            end
            elcwa_pkg::KIND_MAC: begin
                r.key_low[63:48] = '0;
            end
            default: begin
                r.key_high = rand64();
            end
        endcase
        return r;
    endfunction

    task automatic build_key_pool();
        t_cache_req k;
        for (int i = 0; i < POOL_KEYS; i++) begin
            k = shaped_key(elcwa_pkg::REQ_LOOKUP, 2'($urandom_range(0, 2)));
            pool_kind[i] = k.key_kind;
            pool_high[i] = k.key_high;
            pool_low[i]  = k.key_low;
            // now and then the same bits under another kind, which must not match
            if (i > 0 && $urandom_range(0, 9) == 0) begin
                pool_high[i] = pool_high[i-1];
                pool_low[i]  = pool_low[i-1];
                pool_kind[i] = (pool_kind[i-1] == elcwa_pkg::KIND_MAC) ?
                               elcwa_pkg::KIND_IPV4 : pool_kind[i-1] + 2'd1;
            end
        end
    endtask

    // mostly learn and lookup on the pool, some ticks, some noise
    task automatic queue_random_requests(int count);
        int pick;
        int n;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            n = $urandom_range(0, POOL_KEYS - 1);
            if (pick < 45)
                request_backlog.push_back(mk_req(elcwa_pkg::REQ_LEARN, pool_kind[n],
                                                 pool_high[n], pool_low[n],
                                                 8'($urandom), 8'($urandom)));
            else if (pick < 80)
                request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, pool_kind[n],
                                                 pool_high[n], pool_low[n],
                                                 8'($urandom), 8'($urandom)));
            else if (pick < 90)
                request_backlog.push_back(mk_req(elcwa_pkg::REQ_TICK, 2'($urandom), rand64(),
                    rand64(), 8'($urandom), ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                                                                8'($urandom_range(0, 8))));
            else
                request_backlog.push_back(mk_req(2'($urandom), 2'($urandom), rand64(),
                                                 rand64(), 8'($urandom), 8'($urandom)));
        end
    endtask

    // block idle: nothing queued, nothing presented, nothing owed
    task automatic wait_drained();
        do @(posedge i_clk);
        while (request_backlog.size() != 0 || s_valid || awaited_answers.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_lifetime(logic [15:0] secs);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= secs;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        shadow_lifetime = secs;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        t_cache_req k;
        t_cache_req first_key;
        logic [15:0] lifetimes [5];

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset lifetime of 60 s
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'd0, 8'd0));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LEARN, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'd0, 8'd0));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LEARN, elcwa_pkg::KIND_IPV6,
                                         '1, '1, 8'hff, 8'd0));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LEARN, elcwa_pkg::KIND_MAC,
                                         64'd0, 64'h0000_ffff_ffff_ffff, 8'ha5, 8'd0));
        // learn hit keeps the stored endpoint
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LEARN, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'h5a, 8'd0));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_IPV6,
                                         '1, '1, 8'd0, 8'd0));
        // same bits as the mac entry but another kind
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'h0000_ffff_ffff_ffff, 8'd0, 8'd0));
        // one bit off in the upper half
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_IPV6,
                                         64'h7fff_ffff_ffff_ffff, '1, 8'd0, 8'd0));
        // unknown key kind on learn and lookup, unknown request type
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LEARN, elcwa_pkg::KIND_BAD,
                                         64'd0, 64'd1, 8'd1, 8'd0));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_BAD,
                                         64'd0, 64'd1, 8'd0, 8'd0));
        request_backlog.push_back(mk_req(REQ_UNKNOWN, elcwa_pkg::KIND_BAD,
                                         '1, '1, 8'hff, 8'hff));
        // a tick of zero seconds removes nothing while lifetimes are above zero
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_TICK, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'd0, 8'd0));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_TICK, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'd0, 8'd59));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_IPV6,
                                         '1, '1, 8'd0, 8'd0));
        // lifetime exactly used up: the two entries not refreshed go
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_TICK, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'd0, 8'd1));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_TICK, elcwa_pkg::KIND_MAC,
                                         '1, '1, 8'hff, 8'hff));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_IPV6,
                                         '1, '1, 8'd0, 8'd0));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_IPV4,
                                         '1, '1, 8'hff, 8'hff));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LEARN, elcwa_pkg::KIND_IPV4,
                                         '1, 64'h0000_0000_ffff_ffff, 8'h3c, 8'hff));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_LOOKUP, elcwa_pkg::KIND_IPV4,
                                         '1, 64'h0000_0000_ffff_ffff, 8'd0, 8'd0));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_TICK, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'd0, 8'hff));
        wait_drained();

        // fill the table, overflow it, then age every entry out in one tick
        write_lifetime(16'd200);
        first_key = shaped_key(elcwa_pkg::REQ_LEARN, elcwa_pkg::KIND_IPV6);
        request_backlog.push_back(first_key);
        for (int i = 1; i < CACHE_SLOTS + 1; i++)
            request_backlog.push_back(shaped_key(elcwa_pkg::REQ_LEARN,
                                                 2'($urandom_range(0, 2))));
        k = shaped_key(elcwa_pkg::REQ_LEARN, elcwa_pkg::KIND_MAC);
        request_backlog.push_back(k);
        first_key.endpoint_id = ~first_key.endpoint_id;
        request_backlog.push_back(first_key);
        k.req_type = elcwa_pkg::REQ_LOOKUP;
        request_backlog.push_back(k);
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_TICK, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'd0, 8'd199));
        request_backlog.push_back(mk_req(elcwa_pkg::REQ_TICK, elcwa_pkg::KIND_IPV4,
                                         64'd0, 64'd0, 8'd0, 8'd1));
        wait_drained();

        // random phases over several lifetimes, the extremes among them
        lifetimes[0] = 16'hffff;
        lifetimes[1] = 16'd1;
        lifetimes[2] = 16'd0;
        lifetimes[3] = 16'($urandom_range(2, 300));
        lifetimes[4] = elcwa_pkg::LIFETIME_RESET;
        foreach (lifetimes[p]) begin
            write_lifetime(lifetimes[p]);
            sender_gappy = ($urandom_range(0, 3) != 0);
            receiver_gappy = ($urandom_range(0, 3) != 0);
            build_key_pool();
            queue_random_requests(110);
            wait_drained();
        end

        // let any stray late word show up before the verdict
        repeat (2 * CACHE_SLOTS + 20) @(posedge i_clk);
        if (failed || awaited_answers.size() != 0)
            $display("FAILURE");
        else
            $display("SUCCESS");
        $finish;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/elcwa_pkg.sv
rtl/core/elcwa_cell.sv
rtl/core/elcwa_head.sv
rtl/core/endpoint_learning_cache_with_aging_unit.sv
rtl/core/elcwa_checker.sv
bench/tb_endpoint_learning_cache_with_aging_unit.sv
